[sv/i2crb_pkg.sv]
// ----------------------------------------------------------------------------
// i2crb_pkg
// Types and constants shared by the I2C slave register buffer.
// ----------------------------------------------------------------------------
package i2crb_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int IDX_W     = $clog2(BUF_DEPTH);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [7:0]       byte_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_WR_ADDR   = 3'd1,
		PH_WR_OFFSET = 3'd2,
		PH_WR_COUNT  = 3'd3,
		PH_WR_DATA   = 3'd4,
		PH_RD_ADDR   = 3'd5,
		PH_RD_DATA   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		OP_BUS   = 2'd0,
		OP_TX_WR = 2'd1,
		OP_RX_RD = 2'd2
	} op_t;

	typedef struct packed {
		logic   load;
		logic   tx_sel;
		logic   rx_sel;
		logic   tx_vld;
		logic   rx_vld;
		byte_t  count;
		phase_t phase;
	} s1_ctrl_t;

endpackage

[sv/i2crb_in_if.sv]
// ----------------------------------------------------------------------------
// i2crb_in_if
// Input item channel: bus byte events and host buffer accesses.
// ----------------------------------------------------------------------------
interface i2crb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic       data_not_address;
	logic       read_dir;
	logic       buffer_full;
	logic       start_seen;
	logic [7:0] bus_byte;
	logic [4:0] host_index;
	logic [7:0] host_data;

	modport source (
		output valid, op, data_not_address, read_dir, buffer_full, start_seen,
			bus_byte, host_index, host_data,
		input  ready
	);

	modport sink (
		input  valid, op, data_not_address, read_dir, buffer_full, start_seen,
			bus_byte, host_index, host_data,
		output ready
	);
endinterface

[sv/i2crb_out_if.sv]
// ----------------------------------------------------------------------------
// i2crb_out_if
// Result item channel: transmit load, host read data and protocol status.
// ----------------------------------------------------------------------------
interface i2crb_out_if;
	logic       valid;
	logic       ready;
	logic       tx_load;
	logic [7:0] tx_byte;
	logic [7:0] host_read_data;
	logic [7:0] announced_count;
	logic [2:0] protocol_state;

	modport source (
		output valid, tx_load, tx_byte, host_read_data, announced_count, protocol_state,
		input  ready
	);

	modport sink (
		input  valid, tx_load, tx_byte, host_read_data, announced_count, protocol_state,
		output ready
	);
endinterface

[sv/i2crb_ram.sv]
// ----------------------------------------------------------------------------
// i2crb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module i2crb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/i2c_slave_register_buffer.sv]
// ----------------------------------------------------------------------------
// i2c_slave_register_buffer
// Byte-level I2C slave sequencer fronting a receive and a transmit buffer.
//
//   channel  role   handshake      payload
//   req      sink   valid/ready    op, bus flags, bus_byte, host_index/data
//   rsp      source valid/ready    tx_load, tx_byte, host_read_data, status
//
// One item per cycle while rsp is not stalled; an item passes through stage 1,
// which reads the buffer RAMs (registered read), then the output register,
// which holds the result, so an empty stage 1 takes an item while one waits.
// Reset clears the sequencer and the per-entry valid bits; entries never
// written read as zero, so no clearing pass is needed.
// A stalled result holds stage 1 and its RAM read data.
// ----------------------------------------------------------------------------
module i2c_slave_register_buffer
	import i2crb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2crb_in_if.sink    req,
	i2crb_out_if.source rsp
);

	phase_t          phase_q, phase_d;
	byte_t           base_q, base_d;
	byte_t           count_q, count_d;
	idx_t            widx_q, widx_d;
	idx_t            ridx_q, ridx_d;
	logic [BUF_DEPTH-1:0] rx_vld_q, tx_vld_q;

	logic     in_acc, s1_move;
	logic     valid_s1;
	s1_ctrl_t ctrl_s1, ctrl_d;

	logic  rx_we, tx_we;
	idx_t  rx_waddr, rx_raddr, tx_raddr, host_idx;
	byte_t rx_rdata, tx_rdata;

	logic  rsp_valid_q, rsp_load_q;
	byte_t rsp_tx_q, rsp_host_q, rsp_count_q;
	phase_t rsp_phase_q;

	logic wr_addr_ev, wr_data_ev, rd_addr_ev, rd_data_ev;

	assign s1_move   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_move;
	assign in_acc    = req.valid && req.ready;
	assign host_idx  = req.host_index[IDX_W-1:0];

	assign wr_addr_ev = !req.data_not_address && !req.read_dir && req.buffer_full
		&& req.start_seen;
	assign wr_data_ev = req.data_not_address && !req.read_dir && req.buffer_full;
	assign rd_addr_ev = !req.data_not_address && req.read_dir && !req.buffer_full
		&& req.start_seen;
	assign rd_data_ev = req.data_not_address && req.read_dir && !req.buffer_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			base_q   <= '0;
			count_q  <= '0;
			widx_q   <= '0;
			ridx_q   <= '0;
			rx_vld_q <= '0;
			tx_vld_q <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			base_q  <= base_d;
			count_q <= count_d;
			widx_q  <= widx_d;
			ridx_q  <= ridx_d;
			if (rx_we) begin
				rx_vld_q[rx_waddr] <= 1'b1;
			end
			if (tx_we) begin
				tx_vld_q[host_idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		base_d   = base_q;
		count_d  = count_q;
		widx_d   = widx_q;
		ridx_d   = ridx_q;
		rx_we    = 1'b0;
		tx_we    = 1'b0;
		rx_waddr = (phase_q == PH_WR_COUNT) ? base_q[IDX_W-1:0] : widx_q;
		tx_raddr = (phase_q == PH_RD_ADDR) ? base_q[IDX_W-1:0] : ridx_q;
		rx_raddr = host_idx;
		ctrl_d   = '0;
		case (req.op)
			OP_TX_WR: begin
				tx_we = in_acc;
			end
			OP_RX_RD: begin
				ctrl_d.rx_sel = 1'b1;
			end
			OP_BUS: begin
				if (wr_addr_ev) begin
					phase_d = PH_WR_ADDR;
				end else if (wr_data_ev) begin
					case (phase_q)
						PH_WR_ADDR: begin
							base_d  = req.bus_byte;
							phase_d = PH_WR_OFFSET;
						end
						PH_WR_OFFSET: begin
							count_d = req.bus_byte;
							phase_d = PH_WR_COUNT;
						end
						PH_WR_COUNT, PH_WR_DATA: begin
							rx_we   = in_acc;
							widx_d  = rx_waddr + idx_t'(1);
							phase_d = PH_WR_DATA;
						end
						default: begin
						end
					endcase
				end else if (rd_addr_ev) begin
					phase_d     = PH_RD_ADDR;
					ctrl_d.load = 1'b1;
				end else if (rd_data_ev) begin
					if (phase_q == PH_RD_ADDR || phase_q == PH_RD_DATA) begin
						ctrl_d.load   = 1'b1;
						ctrl_d.tx_sel = 1'b1;
						ridx_d        = tx_raddr + idx_t'(1);
						phase_d       = PH_RD_DATA;
					end
				end
			end
			default: begin
			end
		endcase
		ctrl_d.tx_vld = tx_vld_q[tx_raddr];
		ctrl_d.rx_vld = rx_vld_q[rx_raddr];
		ctrl_d.count  = count_d;
		ctrl_d.phase  = phase_d;
	end

	i2crb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (req.bus_byte),
		.re    (in_acc),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	i2crb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (host_idx),
		.wdata (req.host_data),
		.re    (in_acc),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rsp_load_q  <= ctrl_s1.load;
			rsp_tx_q    <= (ctrl_s1.tx_sel && ctrl_s1.tx_vld) ? tx_rdata : '0;
			rsp_host_q  <= (ctrl_s1.rx_sel && ctrl_s1.rx_vld) ? rx_rdata : '0;
			rsp_count_q <= ctrl_s1.count;
			rsp_phase_q <= ctrl_s1.phase;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.tx_load         = rsp_load_q;
	assign rsp.tx_byte         = rsp_tx_q;
	assign rsp.host_read_data  = rsp_host_q;
	assign rsp.announced_count = rsp_count_q;
	assign rsp.protocol_state  = rsp_phase_q;

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_we && tx_we))
		else $error("both buffers written by one item");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.tx_load |-> rsp.tx_byte == 8'd0)
		else $error("transmit byte without load");

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.host_read_data != 8'd0 |-> !rsp.tx_load)
		else $error("host read and transmit load in one result");

	a_first_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && rx_we && phase_q == PH_WR_COUNT
		|=> widx_q == $past(base_q[IDX_W-1:0]) + idx_t'(1))
		else $error("write pointer not started at offset");

endmodule
